// ===== src/lpmf_pkg.sv =====
// Shared codes, constants and controller/datapath signal bundles for the message FIFO.
package lpmf_pkg;

	// Command codes of a request transaction
	localparam logic [1:0] CMD_WR_BEGIN = 2'd0;
	localparam logic [1:0] CMD_WR_DATA  = 2'd1;
	localparam logic [1:0] CMD_RD_BEGIN = 2'd2;
	localparam logic [1:0] CMD_RD_DATA  = 2'd3;

	// Status codes of a response transaction
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_BLOCK = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;

	// Length header size in bytes, and width of header-plus-length sums
	localparam int HDR_BYTES = 4;
	localparam int LEN_SUM_W = 18;

	// Controller to datapath commands
	typedef struct packed {
		logic       latch_item;
		logic       push_hdr;
		logic [1:0] hdr_step;
		logic       set_wr_left;
		logic       push_data;
		logic       scan_start;
		logic       scan_read;
		logic       hdr_shift;
		logic       pop_hdr;
		logic       read_tail;
		logic       pop_data;
		logic       load_rsp;
		logic [1:0] rsp_status;
	} lpmf_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] command;
		logic       wr_busy;
		logic       rd_busy;
		logic       oversize;
		logic       no_room;
		logic       short_hdr;
		logic       ring_empty;
		logic       hdr_too_long;
	} lpmf_sts_t;

endpackage

// ===== src/lpmf_chan_if.sv =====
// Request and response channel interfaces of the message FIFO.
interface lpmf_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] msg_length;
	logic [7:0]  data_byte;
	logic [15:0] read_capacity;

	modport source (output valid, command, msg_length, data_byte, read_capacity, input ready);
	modport sink (input valid, command, msg_length, data_byte, read_capacity, output ready);
endinterface

interface lpmf_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] read_length;
	logic [7:0]  read_byte;

	modport source (output valid, status, read_length, read_byte, input ready);
	modport sink (input valid, status, read_length, read_byte, output ready);
endinterface

// ===== src/lpmf_ctrl.sv =====
// Sequencer of the message FIFO: decodes one transaction and steps the datapath.
module lpmf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  lpmf_pkg::lpmf_sts_t  sts,
	output lpmf_pkg::lpmf_cmd_t  cmd
);
	import lpmf_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_DECIDE  = 3'd1;
	localparam logic [2:0] S_WR_HDR  = 3'd2;
	localparam logic [2:0] S_RD_HDR  = 3'd3;
	localparam logic [2:0] S_HDR_CHK = 3'd4;
	localparam logic [2:0] S_RD_WAIT = 3'd5;
	localparam logic [2:0] S_DONE    = 3'd6;

	localparam logic [2:0] STEP_LAST = 3'(HDR_BYTES - 1);
	localparam logic [2:0] STEP_END  = 3'(HDR_BYTES);

	logic [2:0] state_q, state_d;
	logic [2:0] step_q, step_d;
	logic [1:0] code_q, code_d;
	logic       out_valid_q, out_valid_d;

	// Next state and datapath commands
	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		step_d      = step_q;
		code_d      = code_q;
		out_valid_d = out_valid_q & ~out_ready;
		cmd.hdr_step = step_q[1:0];
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_item = 1'b1;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				step_d = '0;
				case (sts.command)
					CMD_WR_BEGIN: begin
						if (sts.wr_busy || sts.oversize) begin
							code_d  = ST_ERROR;
							state_d = S_DONE;
						end else if (sts.no_room) begin
							code_d  = ST_BLOCK;
							state_d = S_DONE;
						end else begin
							state_d = S_WR_HDR;
						end
					end
					CMD_WR_DATA: begin
						if (!sts.wr_busy) begin
							code_d = ST_ERROR;
						end else begin
							cmd.push_data = 1'b1;
							code_d = ST_OK;
						end
						state_d = S_DONE;
					end
					CMD_RD_BEGIN: begin
						if (sts.rd_busy) begin
							code_d  = ST_ERROR;
							state_d = S_DONE;
						end else if (sts.short_hdr) begin
							code_d  = ST_BLOCK;
							state_d = S_DONE;
						end else begin
							cmd.scan_start = 1'b1;
							state_d = S_RD_HDR;
						end
					end
					default: begin
						if (!sts.rd_busy) begin
							code_d  = ST_ERROR;
							state_d = S_DONE;
						end else if (sts.ring_empty) begin
							code_d  = ST_BLOCK;
							state_d = S_DONE;
						end else begin
							cmd.read_tail = 1'b1;
							state_d = S_RD_WAIT;
						end
					end
				endcase
			end
			S_WR_HDR: begin
				// Push one header byte per cycle, low byte first
				cmd.push_hdr = 1'b1;
				if (step_q == STEP_LAST) begin
					cmd.set_wr_left = 1'b1;
					code_d  = ST_OK;
					state_d = S_DONE;
				end else begin
					step_d = step_q + 3'd1;
				end
			end
			S_RD_HDR: begin
				// Issue header reads, collect each byte from the registered read port in the cycle after its read
				cmd.scan_read = (step_q != STEP_END);
				cmd.hdr_shift = (step_q != 3'd0);
				if (step_q == STEP_END) begin
					state_d = S_HDR_CHK;
				end else begin
					step_d = step_q + 3'd1;
				end
			end
			S_HDR_CHK: begin
				if (sts.hdr_too_long) begin
					code_d = ST_ERROR;
				end else begin
					cmd.pop_hdr = 1'b1;
					code_d = ST_OK;
				end
				state_d = S_DONE;
			end
			S_RD_WAIT: begin
				cmd.pop_data = 1'b1;
				code_d  = ST_OK;
				state_d = S_DONE;
			end
			S_DONE: begin
				// Hand the result to the output register once it is free
				if (!out_valid_q || out_ready) begin
					cmd.load_rsp   = 1'b1;
					cmd.rsp_status = code_q;
					out_valid_d    = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			code_q      <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			code_q      <= code_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== src/lpmf_dp.sv =====
// Datapath of the message FIFO: byte ring, pointers, counters and result register.
module lpmf_dp #(
	parameter int RING_BYTES = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lpmf_pkg::lpmf_cmd_t  cmd,
	output lpmf_pkg::lpmf_sts_t  sts,
	input  logic [1:0]           command,
	input  logic [15:0]          msg_length,
	input  logic [7:0]           data_byte,
	input  logic [15:0]          read_capacity,
	output logic [1:0]           status,
	output logic [15:0]          read_length,
	output logic [7:0]           read_byte
);
	import lpmf_pkg::*;

	localparam int PTR_W = $clog2(RING_BYTES);
	localparam logic [PTR_W-1:0]     PTR_LAST  = PTR_W'(RING_BYTES - 1);
	localparam logic [PTR_W-1:0]     CNT_HDR   = PTR_W'(HDR_BYTES);
	localparam logic [LEN_SUM_W-1:0] SUM_RING  = LEN_SUM_W'(RING_BYTES);
	localparam logic [LEN_SUM_W-1:0] SUM_FREE  = LEN_SUM_W'(RING_BYTES - 1);
	localparam logic [LEN_SUM_W-1:0] SUM_HDR   = LEN_SUM_W'(HDR_BYTES);

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	logic [7:0]       ring_mem [RING_BYTES];
	logic [PTR_W-1:0] head_q, tail_q, scan_q, cnt_q;
	logic [15:0]      wr_left_q, rd_left_q;
	logic [1:0]       cmd_q;
	logic [15:0]      len_q, cap_q;
	logic [7:0]       byte_q, rdata_q;
	logic [31:0]      hdr_q;
	logic [1:0]       status_q;
	logic [15:0]      read_length_q;
	logic [7:0]       read_byte_q;

	logic                 push, ren;
	logic [7:0]           wdata, hdr_byte;
	logic [PTR_W-1:0]     raddr;
	logic [LEN_SUM_W-1:0] total;

	// Select the header byte and the ring write data
	always_comb begin
		case (cmd.hdr_step)
			2'd0:    hdr_byte = len_q[7:0];
			2'd1:    hdr_byte = len_q[15:8];
			default: hdr_byte = 8'h00;
		endcase
	end

	assign push  = cmd.push_hdr | cmd.push_data;
	assign wdata = cmd.push_hdr ? hdr_byte : byte_q;
	assign ren   = cmd.scan_read | cmd.read_tail;
	assign raddr = cmd.scan_read ? scan_q : tail_q;
	assign total = LEN_SUM_W'(len_q) + SUM_HDR;

	// Ring memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (push) begin
			ring_mem[head_q] <= wdata;
		end
		if (ren) begin
			rdata_q <= ring_mem[raddr];
		end
	end

	// Advance pointers, byte count and message counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			cnt_q     <= '0;
			wr_left_q <= '0;
			rd_left_q <= '0;
		end else begin
			if (push) begin
				head_q <= ring_next(head_q);
				cnt_q  <= cnt_q + 1'b1;
			end else if (cmd.pop_data) begin
				tail_q <= ring_next(tail_q);
				cnt_q  <= cnt_q - 1'b1;
			end else if (cmd.pop_hdr) begin
				tail_q <= scan_q;
				cnt_q  <= cnt_q - CNT_HDR;
			end
			if (cmd.set_wr_left) begin
				wr_left_q <= len_q;
			end else if (cmd.push_data) begin
				wr_left_q <= wr_left_q - 16'd1;
			end
			if (cmd.pop_hdr) begin
				rd_left_q <= hdr_q[15:0];
			end else if (cmd.pop_data) begin
				rd_left_q <= rd_left_q - 16'd1;
			end
		end
	end

	// Capture the transaction, gather the header, load the result
	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			cmd_q  <= command;
			len_q  <= msg_length;
			byte_q <= data_byte;
			cap_q  <= read_capacity;
		end
		if (cmd.scan_start) begin
			scan_q <= tail_q;
		end else if (cmd.scan_read) begin
			scan_q <= ring_next(scan_q);
		end
		if (cmd.hdr_shift) begin
			hdr_q <= {rdata_q, hdr_q[31:8]};
		end
		if (cmd.load_rsp) begin
			status_q      <= cmd.rsp_status;
			read_length_q <= (cmd.rsp_status == ST_OK && cmd_q == CMD_RD_BEGIN) ?
				hdr_q[15:0] : 16'd0;
			read_byte_q   <= (cmd.rsp_status == ST_OK && cmd_q == CMD_RD_DATA) ?
				rdata_q : 8'd0;
		end
	end

	// Report conditions to the controller
	assign sts.command      = cmd_q;
	assign sts.wr_busy      = (wr_left_q != 16'd0);
	assign sts.rd_busy      = (rd_left_q != 16'd0);
	assign sts.oversize     = (total > SUM_RING);
	assign sts.no_room      = (LEN_SUM_W'(cnt_q) + total > SUM_FREE);
	assign sts.short_hdr    = (cnt_q < CNT_HDR);
	assign sts.ring_empty   = (cnt_q == '0);
	assign sts.hdr_too_long = (hdr_q > {16'd0, cap_q});

	assign status      = status_q;
	assign read_length = read_length_q;
	assign read_byte   = read_byte_q;

endmodule

// ===== src/length_prefixed_message_fifo.sv =====
// Top level of the length-prefixed message FIFO.
// Queue of messages held in a ring of RING_BYTES bytes (one kept free), each stored
// as a 4-byte little-endian length header and its bytes. One transaction is worked at
// a time by a sequencer over a ring memory that writes one byte and reads one byte a
// cycle: write_begin makes four header pushes, read_begin makes four header reads
// through the registered read port and then the capacity check, whether or not the
// message fits the reader, write_data pushes one byte and read_data reads one byte,
// while an error or would-block result found at decode touches no ring byte. A
// finished transaction waits until the previous result has been taken. The result
// waits in an output register, and the next request is taken while it waits. No
// clearing pass after reset; ring bytes never written are never read.
module length_prefixed_message_fifo #(
	parameter int RING_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	lpmf_req_if.sink    req,
	lpmf_rsp_if.source  rsp
);
	import lpmf_pkg::*;

	lpmf_cmd_t cmd;
	lpmf_sts_t sts;

	lpmf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lpmf_dp #(
		.RING_BYTES (RING_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.command       (req.command),
		.msg_length    (req.msg_length),
		.data_byte     (req.data_byte),
		.read_capacity (req.read_capacity),
		.status        (rsp.status),
		.read_length   (rsp.read_length),
		.read_byte     (rsp.read_byte)
	);

`ifndef SYNTHESIS
	// Never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_rsp |-> (!rsp.valid || rsp.ready))
		else $error("result register overwritten");

	// Push data bytes only inside an accepted message
	a_push_in_msg: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_data |-> sts.wr_busy)
		else $error("data pushed outside a message");

	// Pop data bytes only when stored and owed to the reader
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_data |-> (sts.rd_busy && !sts.ring_empty))
		else $error("data popped from empty ring or outside a message");

	// Pop a header only when it fits the reader
	a_hdr_fits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_hdr |-> !sts.hdr_too_long)
		else $error("header popped over capacity");
`endif

endmodule
